// ===== src/dmm_pkg.sv =====
// shared constants for the division magic multiplier block
package dmm_pkg;

   localparam int WORD_BITS  = 32;
   localparam int DIV_BITS   = 31;
   localparam int SHIFT_BITS = 5;
   localparam int MULT_BITS  = 33;
   localparam int QUO_BITS   = MULT_BITS + 1;
   localparam int IDX_BITS   = $clog2(2 * WORD_BITS);

endpackage

// ===== src/division_magic_multiplier.sv =====
// magic multiplier generator for signed division by an invariant divisor
// Accepts one divisor per request beat and returns post_shift, multiplier and
// log_ceil in one response beat. Work runs through a small sequencer: a bit
// count of divisor-1, then a restoring divider that gives one quotient bit
// per cycle and runs twice, for the low and the high bound, then one halving
// step per cycle while the bounds still differ after halving and the shift is
// not yet zero. The serial divider takes most of the time for an item. A zero
// divisor gives all-zero fields. req_stall is high while an item is at work; a
// finished result may wait in the response register while the next divisor is
// taken.
module division_magic_multiplier (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [dmm_pkg::DIV_BITS-1:0]      req_divisor,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [dmm_pkg::SHIFT_BITS-1:0]    rsp_post_shift,
   output logic [dmm_pkg::MULT_BITS-1:0]     rsp_multiplier,
   output logic [dmm_pkg::SHIFT_BITS-1:0]    rsp_log_ceil
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOG,
      ST_DIV,
      ST_HALVE,
      ST_DONE
   } state_type;

   state_type                          state_ff;
   logic [dmm_pkg::DIV_BITS-1:0]       div_ff;
   logic [dmm_pkg::DIV_BITS-1:0]       cnt_val_ff;
   logic [dmm_pkg::SHIFT_BITS-1:0]     lg_ff;
   logic [dmm_pkg::SHIFT_BITS-1:0]     shift_ff;
   logic [dmm_pkg::DIV_BITS-1:0]       rem_ff;
   logic [dmm_pkg::QUO_BITS-1:0]       quo_ff;
   logic [dmm_pkg::QUO_BITS-1:0]       lo_ff;
   logic [dmm_pkg::QUO_BITS-1:0]       hi_ff;
   logic [dmm_pkg::IDX_BITS-1:0]       idx_ff;
   logic                               sel_ff;
   logic                               rsp_valid_ff;
   logic [dmm_pkg::SHIFT_BITS-1:0]     rsp_post_shift_ff;
   logic [dmm_pkg::MULT_BITS-1:0]      rsp_multiplier_ff;
   logic [dmm_pkg::SHIFT_BITS-1:0]     rsp_log_ceil_ff;

   logic [dmm_pkg::IDX_BITS-1:0]       top_in;
   logic [dmm_pkg::IDX_BITS-1:0]       low_bit_in;
   logic                               bit_in;
   logic [dmm_pkg::DIV_BITS:0]         trial_in;
   logic                               qbit_in;
   logic [dmm_pkg::DIV_BITS:0]         diff_in;
   logic [dmm_pkg::DIV_BITS-1:0]       rem_in;
   logic [dmm_pkg::QUO_BITS-1:0]       quo_in;
   logic                               halve_in;
   logic                               out_free_in;

   // dividend is 2^(N+l), plus 2^(l+1) for the high bound
   assign top_in     = dmm_pkg::IDX_BITS'(dmm_pkg::WORD_BITS) + dmm_pkg::IDX_BITS'(lg_ff);
   assign low_bit_in = dmm_pkg::IDX_BITS'(lg_ff) + dmm_pkg::IDX_BITS'(1);
   assign bit_in     = (idx_ff == top_in) || (sel_ff && (idx_ff == low_bit_in));

   // shared restoring divider step
   assign trial_in = {rem_ff, bit_in};
   assign diff_in  = trial_in - {1'b0, div_ff};
   assign qbit_in  = (trial_in >= {1'b0, div_ff});
   assign rem_in   = qbit_in ? diff_in[dmm_pkg::DIV_BITS-1:0]
                             : trial_in[dmm_pkg::DIV_BITS-1:0];
   assign quo_in   = {quo_ff[dmm_pkg::QUO_BITS-2:0], qbit_in};

   assign halve_in    = ((lo_ff >> 1) < (hi_ff >> 1)) && (shift_ff != '0);
   assign out_free_in = !rsp_valid_ff || !rsp_stall;

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_post_shift = rsp_post_shift_ff;
   assign rsp_multiplier = rsp_multiplier_ff;
   assign rsp_log_ceil   = rsp_log_ceil_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a new result may replace the one taken in this cycle
         if ((state_ff == ST_DONE) && out_free_in) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  div_ff     <= req_divisor;
                  cnt_val_ff <= req_divisor - dmm_pkg::DIV_BITS'(1);
                  lg_ff      <= '0;
                  if (req_divisor == '0) begin
                     shift_ff <= '0;
                     hi_ff    <= '0;
                     state_ff <= ST_DONE;
                  end else begin
                     state_ff <= ST_LOG;
                  end
               end
            end
            ST_LOG: begin
               // bit length of divisor-1
               if (cnt_val_ff == '0) begin
                  rem_ff   <= '0;
                  quo_ff   <= '0;
                  sel_ff   <= 1'b0;
                  idx_ff   <= top_in;
                  state_ff <= ST_DIV;
               end else begin
                  cnt_val_ff <= cnt_val_ff >> 1;
                  lg_ff      <= lg_ff + dmm_pkg::SHIFT_BITS'(1);
               end
            end
            ST_DIV: begin
               if (idx_ff == '0) begin
                  if (!sel_ff) begin
                     lo_ff  <= quo_in;
                     sel_ff <= 1'b1;
                     rem_ff <= '0;
                     quo_ff <= '0;
                     idx_ff <= top_in;
                  end else begin
                     hi_ff    <= quo_in;
                     shift_ff <= lg_ff;
                     state_ff <= ST_HALVE;
                  end
               end else begin
                  rem_ff <= rem_in;
                  quo_ff <= quo_in;
                  idx_ff <= idx_ff - dmm_pkg::IDX_BITS'(1);
               end
            end
            ST_HALVE: begin
               if (halve_in) begin
                  lo_ff    <= lo_ff >> 1;
                  hi_ff    <= hi_ff >> 1;
                  shift_ff <= shift_ff - dmm_pkg::SHIFT_BITS'(1);
               end else begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (out_free_in) begin
                  rsp_post_shift_ff <= shift_ff;
                  rsp_multiplier_ff <= hi_ff[dmm_pkg::MULT_BITS-1:0];
                  rsp_log_ceil_ff   <= lg_ff;
                  state_ff          <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule
